@@ src/assert_macros.svh @@
// Assertion macros used by the request scheduler top level.
// No dependencies; checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ERQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("erq: implication check failed");
`define ERQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("erq: next-cycle check failed");
`else
`define ERQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ERQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/erq_pkg.sv @@
// Types and codes shared by the elevator request scheduler.
// No dependencies.
`timescale 1ns / 1ps

package erq_pkg;

    localparam int TDATA_W = 8;

    localparam logic [1:0] FUNC_NONE   = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    // Input beat, func in the lowest bits
    typedef struct packed {
        logic       car_dir;
        logic [1:0] car_floor;
        logic       req_direction;
        logic [1:0] req_floor;
        logic [1:0] func;
    } item_t;

    // Result beat, target_found in the lowest bit
    typedef struct packed {
        logic       tgt_dir;
        logic [1:0] tgt_floor;
        logic       target_found;
    } result_t;

endpackage

@@ src/erq_pending.sv @@
// Pending up/down request bits and their per-beat update.
// Depends on erq_pkg.
`timescale 1ns / 1ps

module erq_pending
    import erq_pkg::*;
#(
    parameter int FLOORS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              upd_en,
    input  item_t             item,
    output logic [FLOORS-1:0] up_reg,
    output logic [FLOORS-1:0] down_reg,
    output logic [FLOORS-1:0] up_next,
    output logic [FLOORS-1:0] down_next
);

    logic [FLOORS-1:0] bit_sel;
    logic              floor_ok;

    assign floor_ok = int'(item.req_floor) < FLOORS;
    assign bit_sel  = {{(FLOORS-1){1'b0}}, 1'b1} << item.req_floor;

    always_comb begin
        up_next   = up_reg;
        down_next = down_reg;
        unique case (item.func)
            FUNC_ADD: begin
                if (floor_ok) begin
                    if (item.req_direction == DIR_UP) begin
                        up_next = up_reg | bit_sel;
                    end else begin
                        down_next = down_reg | bit_sel;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (floor_ok) begin
                    if (item.req_direction == DIR_UP) begin
                        up_next = up_reg & ~bit_sel;
                    end else begin
                        down_next = down_reg & ~bit_sel;
                    end
                end
            end
            FUNC_CLEAR: begin
                up_next   = '0;
                down_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg   <= '0;
            down_reg <= '0;
        end else if (upd_en) begin
            up_reg   <= up_next;
            down_reg <= down_next;
        end
    end

endmodule

@@ src/erq_search.sv @@
// SCAN target selection over the updated pending bits.
// Depends on erq_pkg.
`timescale 1ns / 1ps

module erq_search
    import erq_pkg::*;
#(
    parameter int FLOORS = 4
) (
    input  logic [FLOORS-1:0] up_pend,
    input  logic [FLOORS-1:0] down_pend,
    input  logic [1:0]        car_floor,
    input  logic              car_dir,
    output result_t           result
);

    localparam int FW = (FLOORS > 4) ? $clog2(FLOORS) : 2;

    logic [FW-1:0]     cf_ext;
    logic [FW-1:0]     cf_sat;
    logic [FLOORS-1:0] ge_mask;
    logic [FLOORS-1:0] le_mask;
    logic [FLOORS-1:0] up_ahead;
    logic [FLOORS-1:0] down_ahead;
    logic [FW-1:0]     up_ahead_lo;
    logic [FW-1:0]     up_lo;
    logic [FW-1:0]     down_ahead_hi;
    logic [FW-1:0]     down_hi;
    logic [FW-1:0]     pick;

    assign cf_ext = FW'(car_floor);
    assign cf_sat = (cf_ext > FW'(FLOORS - 1)) ? FW'(FLOORS - 1) : cf_ext;

    always_comb begin
        for (int i = 0; i < FLOORS; i++) begin
            ge_mask[i] = FW'(i) >= cf_sat;
            le_mask[i] = FW'(i) <= cf_sat;
        end
    end

    assign up_ahead   = up_pend & ge_mask;
    assign down_ahead = down_pend & le_mask;

    // lowest set bits
    always_comb begin
        up_ahead_lo = '0;
        up_lo       = '0;
        for (int i = FLOORS - 1; i >= 0; i--) begin
            if (up_ahead[i]) begin
                up_ahead_lo = FW'(i);
            end
            if (up_pend[i]) begin
                up_lo = FW'(i);
            end
        end
    end

    // highest set bits
    always_comb begin
        down_ahead_hi = '0;
        down_hi       = '0;
        for (int i = 0; i < FLOORS; i++) begin
            if (down_ahead[i]) begin
                down_ahead_hi = FW'(i);
            end
            if (down_pend[i]) begin
                down_hi = FW'(i);
            end
        end
    end

    always_comb begin
        result.target_found = (|up_pend) | (|down_pend);
        result.tgt_dir      = DIR_UP;
        pick                = '0;
        if (car_dir == DIR_UP) begin
            priority if (|up_ahead) begin
                pick = up_ahead_lo;
            end else if (|down_pend) begin
                pick           = down_hi;
                result.tgt_dir = DIR_DOWN;
            end else if (|up_pend) begin
                pick = up_lo;
            end
        end else begin
            priority if (|down_ahead) begin
                pick           = down_ahead_hi;
                result.tgt_dir = DIR_DOWN;
            end else if (|up_pend) begin
                pick = up_lo;
            end else if (|down_pend) begin
                pick           = down_hi;
                result.tgt_dir = DIR_DOWN;
            end
        end
        result.tgt_floor = pick[1:0];
    end

endmodule

@@ src/elevator_request_scheduler.sv @@
// Elevator request scheduler, top level: input register, pending bits,
// SCAN search and result register. Depends on erq_pkg, erq_pending,
// erq_search and assert_macros.svh.
//
// Usage: each beat on the s_ channel carries one request change (none, add,
// remove, clear all) together with the car's floor and travel direction.
// The block applies the change to its pending up/down bits and returns one
// beat on the m_ channel with the next floor to serve, its direction and a
// found flag. Beats are answered strictly in order, one result per beat.
// An accepted beat lands in the input register; its result is then registered in the result register and shown on m_.
// Throughput: one beat per cycle while m_tready is high; the bit update and
// fixed-priority search lie combinationally between the input and result registers.
// Reset (aresetn low, synchronous) clears all pending bits and empties
// both registers. When the receiver holds m_tready low the result waits in
// place; one further beat is held in the input register, after which
// s_tready falls until the result is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module elevator_request_scheduler
    import erq_pkg::*;
#(
    parameter int FLOORS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [1:0] func, [3:2] req_floor, [4] req_direction,
    // [6:5] car_floor, [7] car_dir
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [0] target_found, [2:1] tgt_floor, [3] tgt_dir, [7:4] zero
    output logic [TDATA_W-1:0] m_tdata
);

    item_t             item_reg;
    logic              item_valid_reg;
    result_t           res_reg;
    logic              res_valid_reg;
    result_t           res_next;
    logic              advance;
    logic [FLOORS-1:0] up_reg;
    logic [FLOORS-1:0] down_reg;
    logic [FLOORS-1:0] up_next;
    logic [FLOORS-1:0] down_next;
    logic              res_empty;
    logic              stalled;
    logic              clear_beat;
    logic              add_beat;

    assign advance  = item_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_t'(s_tdata);
        end
    end

    erq_pending #(
        .FLOORS (FLOORS)
    ) u_pending (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd_en    (advance),
        .item      (item_reg),
        .up_reg    (up_reg),
        .down_reg  (down_reg),
        .up_next   (up_next),
        .down_next (down_next)
    );

    erq_search #(
        .FLOORS (FLOORS)
    ) u_search (
        .up_pend   (up_next),
        .down_pend (down_next),
        .car_floor (item_reg.car_floor),
        .car_dir   (item_reg.car_dir),
        .result    (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {{(TDATA_W - $bits(result_t)){1'b0}}, res_reg};

    assign res_empty  = m_tvalid && !m_tdata[0];
    assign stalled    = m_tvalid && !m_tready;
    assign clear_beat = advance && item_reg.func == FUNC_CLEAR;
    assign add_beat   = advance && item_reg.func == FUNC_ADD && int'(item_reg.req_floor) < FLOORS;

    `ERQ_ASSERT_IMPLY(a_empty_zero, aclk, aresetn, res_empty, m_tdata[3:1] == 3'd0)
    `ERQ_ASSERT_IMPLY(a_stall_full, aclk, aresetn, !s_tready, item_valid_reg && stalled)
    `ERQ_ASSERT_NEXT(a_clear_empty, aclk, aresetn, clear_beat, res_empty && ~|up_reg && ~|down_reg)
    `ERQ_ASSERT_NEXT(a_add_found, aclk, aresetn, add_beat, m_tvalid && m_tdata[0])

endmodule
